[hw/rtl/tcce_pkg.sv]
// Package of shared types and constants for the text console character engine.
package tcce_pkg;

  // Default screen geometry.
  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  // Character codes with special meaning.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // A tab expands into this many spaces.
  localparam int unsigned TAB_WIDTH = 8;
  localparam int unsigned TAB_W     = $clog2(TAB_WIDTH);

  // Commands.
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOUR = 2'd1;

  // Reset values.
  localparam logic [3:0]  FG_RESET   = 4'd7;
  localparam logic [3:0]  BG_RESET   = 4'd0;
  localparam logic [15:0] CELL_RESET = 16'h0720;

  // Field widths.
  localparam int unsigned LOC_W  = 11;
  localparam int unsigned CELL_W = 16;

  // Input item.
  typedef struct packed {
    logic             cmd;
    logic [7:0]       char_code;
    logic [LOC_W-1:0] cell_index;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [LOC_W-1:0]  cursor_location;
    logic [CELL_W-1:0] cell_word;
  } out_item_t;

endpackage

[hw/rtl/text_console_char_engine.sv]
// Text console character engine: cursor control and screen store with scrolling.
// A put or NUL item passes the execute and hand-off steps; a read adds a wait for the memory read.
// Only one item is in flight at a time: input stalls until its result is handed off.
// A wrap or newline past the last row adds a scroll through the separate write and read
// ports of the screen memory (copy one cell a cycle, then blank one row).
// After reset a clearing pass fills the store with grey blanks.
module text_console_char_engine
  import tcce_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [3:0]           cfg_data_i
);

  localparam int unsigned CELLS  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_RWAIT  = 7'b0001000,
    ST_SCROLL = 7'b0010000,
    ST_FILL   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [3:0]         fg_q, fg_d, bg_q, bg_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ADDR_W-1:0]  ptr_q, ptr_d;
  logic               cp_pend_q, cp_pend_d;
  logic [ADDR_W-1:0]  cp_dst_q, cp_dst_d;
  logic               more_q, more_d;
  logic [TAB_W-1:0]   tab_cnt_q, tab_cnt_d;
  in_item_t           item_q, item_d;
  logic               rd_ok_q, rd_ok_d;
  logic [CELL_W-1:0]  word_q, word_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  // Screen memory ports.
  logic [CELL_W-1:0]  mem_q [CELLS];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa, mem_ra;
  logic [CELL_W-1:0]  mem_wd, rdata_q;

  logic [7:0]         attr;
  logic [ADDR_W-1:0]  cur_addr, bs_addr;
  logic [31:0]        loc32;
  logic               is_tab, last_col, last_row, more_now, wrap;

  assign attr     = {bg_q, fg_q};
  assign cur_addr = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));
  assign bs_addr  = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q) - 32'd1);
  assign loc32    = 32'(row_q) * COLUMNS + 32'(col_q);
  assign is_tab   = (item_q.char_code == CHAR_TAB);
  assign last_col = (32'(col_q) == COLUMNS - 1);
  assign last_row = (32'(row_q) == ROWS - 1);
  assign more_now = is_tab && (tab_cnt_q != TAB_W'(TAB_WIDTH - 1));
  assign wrap     = (item_q.char_code == CHAR_LF) || last_col;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Configuration registers.
  always_comb begin
    fg_d = fg_q;
    bg_d = bg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FG_COLOUR: fg_d = cfg_data_i;
        CFG_BG_COLOUR: bg_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: clearing pass, item steps, scroll copy and fill, result hand-off.
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    ptr_d       = ptr_q;
    cp_pend_d   = 1'b0;
    cp_dst_d    = cp_dst_q;
    more_d      = more_q;
    tab_cnt_d   = tab_cnt_q;
    item_d      = item_q;
    rd_ok_d     = rd_ok_q;
    word_d      = word_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_wa      = cur_addr;
    mem_wd      = {attr, CHAR_SPACE};
    mem_ra      = ptr_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = ptr_q;
        mem_wd = CELL_RESET;
        if (32'(ptr_q) == CELLS - 1) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d    = in_item_i;
          tab_cnt_d = '0;
          more_d    = 1'b0;
          word_d    = '0;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (item_q.cmd == CMD_READ) begin
          mem_ra  = ADDR_W'(item_q.cell_index);
          rd_ok_d = (32'(item_q.cell_index) < CELLS);
          state_d = ST_RWAIT;
        end else if (item_q.char_code == CHAR_NUL) begin
          state_d = ST_DONE;
        end else if (item_q.char_code == CHAR_BS) begin
          if (col_q != '0) begin
            mem_we = 1'b1;
            mem_wa = bs_addr;
            col_d  = col_q - 1'b1;
          end
          state_d = ST_DONE;
        end else begin
          // Newline, or one printable step (a tab step writes a space).
          if (item_q.char_code != CHAR_LF) begin
            mem_we    = 1'b1;
            mem_wd    = {attr, is_tab ? CHAR_SPACE : item_q.char_code};
            tab_cnt_d = tab_cnt_q + 1'b1;
            more_d    = more_now;
          end else begin
            more_d = 1'b0;
          end
          if (!wrap) begin
            col_d   = col_q + 1'b1;
            state_d = (item_q.char_code != CHAR_LF && more_now) ? ST_EXEC : ST_DONE;
          end else begin
            col_d = '0;
            if (last_row) begin
              ptr_d   = ADDR_W'(COLUMNS);
              state_d = ST_SCROLL;
            end else begin
              row_d   = row_q + 1'b1;
              state_d = (item_q.char_code != CHAR_LF && more_now) ? ST_EXEC : ST_DONE;
            end
          end
        end
      end
      ST_RWAIT: begin
        word_d  = rd_ok_q ? rdata_q : '0;
        state_d = ST_DONE;
      end
      ST_SCROLL: begin
        // Read one row below; the cell lands one row up in the next cycle.
        mem_ra    = ptr_q;
        cp_pend_d = 1'b1;
        cp_dst_d  = ptr_q - ADDR_W'(COLUMNS);
        if (cp_pend_q) begin
          mem_we = 1'b1;
          mem_wa = cp_dst_q;
          mem_wd = rdata_q;
        end
        if (32'(ptr_q) == CELLS - 1) begin
          ptr_d   = ADDR_W'(CELLS - COLUMNS);
          state_d = ST_FILL;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (cp_pend_q) begin
          mem_wa = cp_dst_q;
          mem_wd = rdata_q;
        end else begin
          mem_wa = ptr_q;
          mem_wd = {attr, CHAR_SPACE};
          if (32'(ptr_q) == CELLS - 1) begin
            state_d = more_q ? ST_EXEC : ST_DONE;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d               = 1'b1;
          out_d.cursor_location     = loc32[LOC_W-1:0];
          out_d.cell_word           = word_q;
          state_d                   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      fg_q        <= FG_RESET;
      bg_q        <= BG_RESET;
      row_q       <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      cp_pend_q   <= 1'b0;
      more_q      <= 1'b0;
      tab_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fg_q        <= fg_d;
      bg_q        <= bg_d;
      row_q       <= row_d;
      col_q       <= col_d;
      ptr_q       <= ptr_d;
      cp_pend_q   <= cp_pend_d;
      more_q      <= more_d;
      tab_cnt_q   <= tab_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cp_dst_q <= cp_dst_d;
    item_q   <= item_d;
    rd_ok_q  <= rd_ok_d;
    word_q   <= word_d;
    out_q    <= out_d;
  end

  // Screen memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[mem_ra];
  end

  // The cursor always stays on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
    else $error("cursor off screen");

  // A new result only comes out of the hand-off step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result without hand-off");

  // Pending copy writes exist only while scrolling.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_pend_q |-> (state_q == ST_SCROLL || state_q == ST_FILL))
    else $error("stray copy write");

  // A scroll runs only with the cursor on the last row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL || state_q == ST_FILL) |-> (32'(row_q) == ROWS - 1))
    else $error("scroll off last row");

  // A finished result is never overwritten while it is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_item_o))
    else $error("stalled result changed");

endmodule
